// ----- hw/rtl/hshc_pkg.sv -----
// Package for the heater safety hysteresis controller.
// Holds field widths, mode and register codes and the struct types shared by
// hshc_step and the top level. Depends on nothing.
package hshc_pkg;

  localparam int TEMP_W  = 16;  // signed Q12.4 temperatures
  localparam int HYST_W  = 12;  // unsigned Q8.4 bands and margins
  localparam int POWER_W = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TEMP_W;

  localparam logic [POWER_W-1:0] FULL_DRIVE = 8'd255;

  // Controller modes
  localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FULL     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MODULATE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MAINTAIN = 2'd3;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_AIR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEATER_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEATER_HYST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_HYST    = 3'd5;

  // Register reset values
  localparam logic [TEMP_W-1:0] RST_TARGET_AIR  = 16'd960;
  localparam logic [TEMP_W-1:0] RST_HEATER_LIM  = 16'd1600;
  localparam logic [HYST_W-1:0] RST_HEATER_HYST = 12'd80;
  localparam logic [HYST_W-1:0] RST_FULL_MARGIN = 12'd80;
  localparam logic [HYST_W-1:0] RST_AIR_HYST    = 12'd16;

  typedef struct packed {
    logic signed [TEMP_W-1:0] heater_sample;
    logic signed [TEMP_W-1:0] air_sample;
  } hshc_in_t;

  typedef struct packed {
    logic [POWER_W-1:0] heater_power;
    logic [MODE_W-1:0]  mode_now;
    logic               lockout_now;
  } hshc_out_t;

  typedef struct packed {
    logic                     controller_enable;
    logic signed [TEMP_W-1:0] target_air_temp;
    logic signed [TEMP_W-1:0] heater_temp_limit;
    logic [HYST_W-1:0]        heater_hysteresis;
    logic [HYST_W-1:0]        full_power_margin;
    logic [HYST_W-1:0]        air_hysteresis;
  } hshc_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              lockout;
    logic              drive_on;
  } hshc_state_t;

endpackage

// ----- hw/rtl/heater_safety_hysteresis_controller.sv -----
// Heater safety hysteresis controller, top level. Depends on hshc_pkg, hshc_step.
// A request passes through the input stage and then the result register to out_data.
// Throughput: one request per cycle while out_stall does not hold the result; the
// mode/lockout/drive feedback closes through hshc_step and the state register.
// Reset (rst, synchronous): mode idle, lockout clear, drive off, registers at
// their defaults, both stages empty.
module heater_safety_hysteresis_controller import hshc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hshc_in_t              in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output hshc_out_t             out_data,
  // Register write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  hshc_cfg_t   cfg;
  hshc_state_t state;
  hshc_state_t state_next;

  // Input stage
  logic        stage_valid;
  hshc_in_t    stage_data;
  logic        stage_move;

  // The stage moves into the result register whenever that register is free
  // or is being taken this cycle; a request enters whenever the stage empties.
  assign stage_move = stage_valid && (!out_valid || !out_stall);
  assign in_stall   = stage_valid && !stage_move;

  // Register file: writes to unused indexes fall through the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.controller_enable <= 1'b1;
      cfg.target_air_temp   <= RST_TARGET_AIR;
      cfg.heater_temp_limit <= RST_HEATER_LIM;
      cfg.heater_hysteresis <= RST_HEATER_HYST;
      cfg.full_power_margin <= RST_FULL_MARGIN;
      cfg.air_hysteresis    <= RST_AIR_HYST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE:      cfg.controller_enable <= cfg_data[0];
        REG_TARGET_AIR:  cfg.target_air_temp   <= cfg_data[TEMP_W-1:0];
        REG_HEATER_LIM:  cfg.heater_temp_limit <= cfg_data[TEMP_W-1:0];
        REG_HEATER_HYST: cfg.heater_hysteresis <= cfg_data[HYST_W-1:0];
        REG_FULL_MARGIN: cfg.full_power_margin <= cfg_data[HYST_W-1:0];
        REG_AIR_HYST:    cfg.air_hysteresis    <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture a request into the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_data <= in_data;
    end
  end

  hshc_step u_step (
    .cfg        (cfg),
    .state      (state),
    .sample     (stage_data),
    .state_next (state_next)
  );

  // Advance the controller state only when a request leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode     <= MODE_IDLE;
      state.lockout  <= 1'b0;
      state.drive_on <= 1'b0;
    end else if (stage_move) begin
      state <= state_next;
    end
  end

  // Result register: hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_data.heater_power <= state_next.drive_on ? FULL_DRIVE : '0;
      out_data.mode_now     <= state_next.mode;
      out_data.lockout_now  <= state_next.lockout;
    end
  end

endmodule

// ----- hw/rtl/hshc_step.sv -----
// Next-state logic of the heater safety hysteresis controller: one request in,
// the mode, lockout and drive after it out. Purely combinational.
// Depends on hshc_pkg.
module hshc_step import hshc_pkg::*; (
  input  hshc_cfg_t   cfg,
  input  hshc_state_t state,
  input  hshc_in_t    sample,
  output hshc_state_t state_next
);

  // Two extra bits hold every sum and difference of a temperature and a band.
  localparam int WW = TEMP_W + 2;

  logic signed [WW-1:0] heater_w;
  logic signed [WW-1:0] air_w;
  logic signed [WW-1:0] limit_w;
  logic signed [WW-1:0] target_w;
  logic signed [WW-1:0] release_w;
  logic signed [WW-1:0] full_on_w;
  logic signed [WW-1:0] band_lo_w;
  logic signed [WW-1:0] band_hi_w;
  logic                 lockout_held;
  logic                 lockout_next;

  assign heater_w = {{(WW-TEMP_W){sample.heater_sample[TEMP_W-1]}}, sample.heater_sample};
  assign air_w    = {{(WW-TEMP_W){sample.air_sample[TEMP_W-1]}}, sample.air_sample};
  assign limit_w  = {{(WW-TEMP_W){cfg.heater_temp_limit[TEMP_W-1]}}, cfg.heater_temp_limit};
  assign target_w = {{(WW-TEMP_W){cfg.target_air_temp[TEMP_W-1]}}, cfg.target_air_temp};

  assign release_w = limit_w  - {{(WW-HYST_W){1'b0}}, cfg.heater_hysteresis};
  assign full_on_w = target_w - {{(WW-HYST_W){1'b0}}, cfg.full_power_margin};
  assign band_lo_w = target_w - {{(WW-HYST_W){1'b0}}, cfg.air_hysteresis};
  assign band_hi_w = target_w + {{(WW-HYST_W){1'b0}}, cfg.air_hysteresis};

  // Lockout stays while the heater is above the release point.
  assign lockout_held = state.lockout && (heater_w > release_w);
  assign lockout_next = lockout_held;

  always_comb begin
    state_next = state;
    if (!cfg.controller_enable) begin
      state_next.mode     = MODE_IDLE;
      state_next.drive_on = 1'b0;
    end else if (heater_w >= limit_w) begin
      state_next.mode     = MODE_IDLE;
      state_next.drive_on = 1'b0;
      state_next.lockout  = 1'b1;
    end else if (lockout_held && state.mode == MODE_IDLE) begin
      // Locked out in idle: hold everything.
      state_next = state;
    end else begin
      state_next.lockout = lockout_next;
      case (state.mode)
        MODE_IDLE: begin
          if (air_w < full_on_w && !lockout_next) begin
            state_next.mode     = MODE_FULL;
            state_next.drive_on = 1'b1;
          end else begin
            state_next.drive_on = 1'b0;
          end
        end
        MODE_FULL: begin
          if (heater_w >= limit_w) begin
            state_next.mode     = MODE_MODULATE;
            state_next.drive_on = 1'b1;
          end else if (air_w >= band_lo_w) begin
            state_next.mode = MODE_MAINTAIN;
          end else begin
            state_next.drive_on = 1'b1;
          end
        end
        MODE_MODULATE: begin
          if (air_w >= band_lo_w) begin
            state_next.mode = MODE_MAINTAIN;
          end else if (heater_w > limit_w) begin
            state_next.drive_on = 1'b0;
          end else if (heater_w < release_w) begin
            state_next.drive_on = 1'b1;
          end
        end
        default: begin
          if (air_w > band_hi_w) begin
            state_next.drive_on = 1'b0;
          end else if (air_w < band_lo_w) begin
            state_next.drive_on = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
